@@ src/bal_pkg.sv @@
// Shared types and codes for the bounded array list.
`default_nettype none
package bal_pkg;

  // Request codes carried in the input tuser.
  typedef enum logic [2:0] {
    REQ_APPEND  = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_READ    = 3'd2,
    REQ_REMOVE  = 3'd3,
    REQ_COMPARE = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_t;

  // Result status codes carried in the output tuser.
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_OOB  = 2'd2
  } status_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  localparam int REQ_W     = 3;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int LIMIT_W   = 7;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 48;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

endpackage
`default_nettype wire

@@ src/bal_cell.sv @@
// One storage cell of the list row, shifting with its neighbors on insert and remove.
`default_nettype none
module bal_cell #(
  parameter int IDX = 0,
  parameter int DW  = 32,
  parameter int PW  = 7
) (
  input  wire                  clk,
  input  wire  bal_pkg::cell_op_t op,
  input  wire  [PW-1:0]        pos,
  input  wire  [DW-1:0]        value,
  input  wire  [DW-1:0]        left_data,
  input  wire  [DW-1:0]        right_data,
  output logic [DW-1:0]        data,
  output logic [DW-1:0]        rd_data,
  output logic                 eq
);
  import bal_pkg::*;

  logic here;
  logic above;

  assign here  = (pos == PW'(IDX));
  assign above = (PW'(IDX) > pos);

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_WRITE: begin
        if (here) data <= value;
      end
      CELL_INSERT: begin
        if (here) data <= value;
        else if (above) data <= left_data;
      end
      CELL_REMOVE: begin
        if (here || above) data <= right_data;
      end
      default: begin
      end
    endcase
  end

  assign rd_data = here ? data : '0;
  assign eq      = here && (data == value);

endmodule
`default_nettype wire

@@ src/bounded_array_list_top.sv @@
// Bounded array list: a row of cells holding an ordered list with indexed insert and remove.
// A result is registered when its request transaction is accepted and presented in the cycle after.
// Throughput: one request per cycle while the output is taken; every cell shifts in the
// same cycle, so an insert or remove costs no more than a read.
// Reset clears the element count and sets the length limit to 64; cell contents are
// left as they are, since no cell at or above the count is ever read.
`default_nettype none
module bounded_array_list_top #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire  [bal_pkg::LIMIT_W-1:0]       cfg_wr_data,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: position[5:0], element_value[37:6], zero pad[39:38].
  input  wire  [bal_pkg::IN_DATA_W-1:0]     s_tdata,
  // Fields from bit 0: req_type[2:0].
  input  wire  [bal_pkg::REQ_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // Fields from bit 0: read_value[31:0], is_match[32], element_count[39:33],
  // empty_flag[40], full_flag[41], zero pad[47:42].
  output logic [bal_pkg::OUT_DATA_W-1:0]    m_tdata,
  // Fields from bit 0: status[1:0].
  output logic [bal_pkg::STATUS_W-1:0]      m_tuser
);
  import bal_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  logic [LIMIT_W-1:0]    limit;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  acc;

  logic [PW-1:0]         cnt_w;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         lim_w;
  logic                  full_now;
  logic                  full_after;

  logic [DATA_WIDTH-1:0] value;
  cell_op_t              op;
  logic [PW-1:0]         cell_pos;
  logic [STATUS_W-1:0]   status_next;
  logic [VAL_W-1:0]      rd_next;
  logic                  match_next;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
  logic [DEPTH-1:0]      cell_eq;
  logic [DATA_WIDTH-1:0] rd_any;

  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;
  assign value    = DATA_WIDTH'(s_tdata[POS_W +: VAL_W]);
  assign cnt_w    = PW'(count);
  assign pos_w    = PW'(s_tdata[POS_W-1:0]);

  // Effective limit saturates into 1..DEPTH.
  always_comb begin
    if (limit == '0) lim_w = PW'(1);
    else if (PW'(limit) > PW'(DEPTH)) lim_w = PW'(DEPTH);
    else lim_w = PW'(limit);
  end

  assign full_now = (cnt_w >= lim_w);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      if (g == 0) begin : g_first
        assign left_d = value;
      end else begin : g_mid
        assign left_d = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_d = cell_data[g];
      end else begin : g_inner
        assign right_d = cell_data[g+1];
      end
      bal_cell #(
        .IDX (g),
        .DW  (DATA_WIDTH),
        .PW  (PW)
      ) u_cell (
        .clk        (clk),
        .op         (op),
        .pos        (cell_pos),
        .value      (value),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_data[g]),
        .rd_data    (cell_rd[g]),
        .eq         (cell_eq[g])
      );
    end
  endgenerate

  // Only the addressed cell drives nonzero data, so an OR collects the read.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  always_comb begin
    op          = CELL_HOLD;
    cell_pos    = pos_w;
    status_next = ST_DONE;
    rd_next     = '0;
    match_next  = 1'b0;
    count_next  = count;
    case (s_tuser)
      REQ_APPEND: begin
        if (full_now) begin
          status_next = ST_FULL;
        end else begin
          op         = CELL_WRITE;
          cell_pos   = cnt_w;
          count_next = count + CW'(1);
        end
      end
      REQ_INSERT: begin
        if (full_now) begin
          status_next = ST_FULL;
        end else if (pos_w > cnt_w) begin
          status_next = ST_OOB;
        end else begin
          op         = CELL_INSERT;
          count_next = count + CW'(1);
        end
      end
      REQ_READ: begin
        if (pos_w >= cnt_w) status_next = ST_OOB;
        else rd_next = VAL_W'(rd_any);
      end
      REQ_REMOVE: begin
        if (pos_w >= cnt_w) begin
          status_next = ST_OOB;
        end else begin
          op         = CELL_REMOVE;
          count_next = count - CW'(1);
        end
      end
      REQ_COMPARE: begin
        if (pos_w >= cnt_w) status_next = ST_OOB;
        else match_next = |cell_eq;
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    if (!acc) op = CELL_HOLD;
  end

  assign full_after = (PW'(count_next) >= lim_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit    <= LIMIT_RESET;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) limit <= cfg_wr_data;
      if (acc) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
        m_tdata  <= {6'd0, full_after, (count_next == '0), COUNT_W'(count_next),
                     match_next, rd_next};
        m_tuser  <= status_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    PW'(count) <= PW'(DEPTH))
    else $error("element count above depth");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(count))
    else $error("element count changed without a transaction");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (acc && s_tuser == REQ_CLEAR) |=> (count == '0))
    else $error("clear did not empty the list");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && !acc) |=> !m_tvalid)
    else $error("result appeared without a request");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the bounded array list top level.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import bal_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 8;

  // Request codes the block has no operation for; it must leave the list alone.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [LIMIT_W-1:0]    cfg_wr_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [REQ_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  // Set for the closing phase, where neither side idles.
  bit calm = 1'b0;
  int unsigned gap_odds = 2;

  int unsigned phase_limit [PHASES] = '{127, 33, 2, 0, 100, 1, 64, 5};
  bit          phase_grow  [PHASES] = '{1, 0, 1, 1, 1, 0, 1, 0};
  int unsigned phase_items [PHASES] = '{120, 80, 60, 50, 90, 50, 90, 60};

  class list_scoreboard;
    typedef struct {
      logic [VAL_W-1:0]   read_value;
      logic               is_match;
      status_t            status;
      logic [COUNT_W-1:0] element_count;
      logic               empty_flag;
      logic               full_flag;
    } list_result_t;

    logic [VAL_W-1:0] cells [LIST_DEPTH];
    int unsigned      count;
    int unsigned      length_limit;
    int               errors;
    list_result_t     awaited_results [$];

    function new();
      count        = 0;
      length_limit = LIMIT_RESET;
      errors       = 0;
    endfunction

    // The register is saturated into 1..DEPTH before use.
    function int unsigned capacity();
      if (length_limit < 1) return 1;
      if (length_limit > LIST_DEPTH) return LIST_DEPTH;
      return length_limit;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      length_limit = value;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val);
      list_result_t r;
      bit           was_full;
      r.read_value = '0;
      r.is_match   = 1'b0;
      r.status     = ST_DONE;
      was_full     = count >= capacity();
      case (req)
        REQ_APPEND: begin
          if (was_full) begin
            r.status = ST_FULL;
          end else begin
            cells[count] = val;
            count++;
          end
        end
        REQ_INSERT: begin
          // Fullness is judged before the index.
          if (was_full) begin
            r.status = ST_FULL;
          end else if (pos > count) begin
            r.status = ST_OOB;
          end else begin
            for (int i = count; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = val;
            count++;
          end
        end
        REQ_READ: begin
          if (pos >= count) r.status = ST_OOB;
          else r.read_value = cells[pos];
        end
        REQ_REMOVE: begin
          if (pos >= count) begin
            r.status = ST_OOB;
          end else begin
            for (int i = pos; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        REQ_COMPARE: begin
          if (pos >= count) r.status = ST_OOB;
          else r.is_match = (cells[pos] == val);
        end
        REQ_CLEAR: count = 0;
        default: ;
      endcase
      r.element_count = COUNT_W'(count);
      r.empty_flag    = (count == 0);
      r.full_flag     = (count >= capacity());
      awaited_results.push_back(r);
    endfunction

    function void match_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] user);
      list_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: tdata %h tuser %h", data, user);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      match_field("read_value", want.read_value, data[31:0]);
      match_field("is_match", want.is_match, data[32]);
      match_field("element_count", want.element_count, data[39:33]);
      match_field("empty_flag", want.empty_flag, data[40]);
      match_field("full_flag", want.full_flag, data[41]);
      match_field("status", want.status, user);
    endfunction

    function void report_leftovers();
      foreach (awaited_results[i]) begin
        $error("result never arrived: count %0d status %0d",
               awaited_results[i].element_count, awaited_results[i].status);
        errors++;
      end
    endfunction
  endclass

  list_scoreboard sb;

  bounded_array_list_top #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (VAL_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** bounded_array_list_top: FAILED **");
    $finish;
  end

  // Result side: random stall bursts, none in the closing phase.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  task automatic idle_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic send_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] val);
    if (!calm && gap_odds != 0 && $urandom_range(1, 4) <= gap_odds)
      idle_sender($urandom_range(1, 6));
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {2'b00, val, pos};
    do @(posedge clk); while (!s_tready);
    sb.note_request(req, pos, val);
  endtask

  // The list must be quiet before the limit changes, so wait out every result.
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    sb.set_limit(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [REQ_W-1:0] pick_request(bit growing);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 45) return REQ_APPEND;
      if (roll < 75) return REQ_INSERT;
      if (roll < 82) return REQ_READ;
      if (roll < 89) return REQ_COMPARE;
      if (roll < 96) return REQ_REMOVE;
    end else begin
      if (roll < 40) return REQ_REMOVE;
      if (roll < 52) return REQ_APPEND;
      if (roll < 62) return REQ_INSERT;
      if (roll < 76) return REQ_READ;
      if (roll < 90) return REQ_COMPARE;
      if (roll < 93) return REQ_CLEAR;
    end
    return $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
  endfunction

  task automatic random_request(bit growing);
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int unsigned      live;
    req  = pick_request(growing);
    live = sb.count;
    // Mostly legal indexes, with some anywhere in the field's range.
    if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, LIST_DEPTH - 1));
    else if (req == REQ_INSERT) pos = POS_W'($urandom_range(0, live > 63 ? 63 : live));
    else pos = (live == 0) ? '0 : POS_W'($urandom_range(0, live - 1));
    case ($urandom_range(0, 7))
      0: val = '0;
      1: val = '1;
      default: val = $urandom();
    endcase
    if (req == REQ_COMPARE && pos < live && $urandom_range(0, 1)) val = sb.cells[pos];
    send_request(req, pos, val);
  endtask

  initial begin
    sb = new();
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= REQ_APPEND;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list, index edges, every operation, spare codes.
    send_request(REQ_CLEAR, 6'd0, 32'h0);
    send_request(REQ_READ, 6'd0, 32'h0);
    send_request(REQ_REMOVE, 6'd0, 32'h0);
    send_request(REQ_COMPARE, 6'd0, 32'h0);
    send_request(REQ_INSERT, 6'd1, 32'hDEAD_BEEF);
    send_request(REQ_INSERT, 6'd0, 32'hFFFF_FFFF);
    send_request(REQ_APPEND, 6'd63, 32'h0000_0000);
    send_request(REQ_APPEND, 6'd0, 32'hA5A5_5A5A);
    send_request(REQ_INSERT, 6'd3, 32'h1234_5678);
    send_request(REQ_INSERT, 6'd1, 32'h8000_0001);
    send_request(REQ_READ, 6'd0, 32'h0);
    send_request(REQ_READ, 6'd4, 32'h0);
    send_request(REQ_COMPARE, 6'd2, 32'h0000_0000);
    send_request(REQ_COMPARE, 6'd1, 32'h0000_0000);
    send_request(REQ_READ, 6'd5, 32'h0);
    send_request(REQ_REMOVE, 6'd2, 32'h0);
    send_request(REQ_REMOVE, 6'd3, 32'h0);
    send_request(REQ_SPARE_LO, 6'd63, 32'hFFFF_FFFF);
    send_request(REQ_SPARE_HI, 6'd0, 32'h0);
    send_request(REQ_READ, 6'd63, 32'h0);
    send_request(REQ_COMPARE, 6'd63, 32'hFFFF_FFFF);

    // Limit dropped under the count: the list is full, yet still readable.
    write_limit(7'd1);
    send_request(REQ_APPEND, 6'd0, 32'h5555_AAAA);
    send_request(REQ_INSERT, 6'd63, 32'h5555_AAAA);
    send_request(REQ_READ, 6'd2, 32'h0);
    send_request(REQ_REMOVE, 6'd0, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      write_limit(LIMIT_W'(phase_limit[p]));
      gap_odds = $urandom_range(0, 3);
      calm     = (p == PHASES - 1);
      repeat (phase_items[p]) random_request(phase_grow[p]);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    sb.report_leftovers();
    if (sb.errors == 0) begin
      $display("** bounded_array_list_top: PASSED **");
    end else begin
      $display("** bounded_array_list_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
